FILE: rtl/core/abe_pkg.sv
`timescale 1ns / 1ps

package abe_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CMD_W     = 5;
    localparam int unsigned IMM_W     = 16;
    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned FLAGS_W   = 3;
    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 168;

    // One-hot condition flag positions
    localparam int unsigned FLAG_P = 0;
    localparam int unsigned FLAG_N = 1;
    localparam int unsigned FLAG_Z = 2;

    localparam logic [WORD_W-1:0] WORD_STEP = 32'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOP    = 5'd0,
        CMD_HALT   = 5'd1,
        CMD_MOVC   = 5'd2,
        CMD_ADD    = 5'd3,
        CMD_SUB    = 5'd4,
        CMD_MUL    = 5'd5,
        CMD_AND    = 5'd6,
        CMD_OR     = 5'd7,
        CMD_XOR    = 5'd8,
        CMD_CML    = 5'd9,
        CMD_JUMP   = 5'd10,
        CMD_CMP    = 5'd11,
        CMD_BZ     = 5'd12,
        CMD_BNZ    = 5'd13,
        CMD_BP     = 5'd14,
        CMD_BNP    = 5'd15,
        CMD_BN     = 5'd16,
        CMD_BNN    = 5'd17,
        CMD_ADDL   = 5'd18,
        CMD_SUBL   = 5'd19,
        CMD_LOAD   = 5'd20,
        CMD_LOADP  = 5'd21,
        CMD_STORE  = 5'd22,
        CMD_STOREP = 5'd23,
        CMD_JALR   = 5'd24
    } cmd_t;

    typedef logic [FLAGS_W-1:0] flags_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [WORD_W-1:0] first_operand;
        logic signed [WORD_W-1:0] second_operand;
        logic signed [IMM_W-1:0]  immediate;
        logic [ADDR_W-1:0]        instr_address;
    } instr_t;

    typedef struct packed {
        logic                     dest_write;
        logic signed [WORD_W-1:0] dest_value;
        logic                     base_write;
        logic signed [WORD_W-1:0] base_value;
        logic                     mem_read;
        logic                     mem_write;
        logic signed [WORD_W-1:0] mem_addr;
        logic signed [WORD_W-1:0] store_data;
        logic                     redirect;
        logic signed [WORD_W-1:0] redirect_addr;
        logic                     halted;
    } result_t;

endpackage

FILE: rtl/core/abe_input_stage.sv
`timescale 1ns / 1ps

module abe_input_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [abe_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          take,
    output logic                          valid,
    output abe_pkg::instr_t               instr
);
    import abe_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    instr_t instr_reg;
    instr_t instr_unpacked;

    // Unpack the stream word, lowest field first
    always_comb
    begin
        instr_unpacked.command        = s_tdata[4:0];
        instr_unpacked.first_operand  = s_tdata[36:5];
        instr_unpacked.second_operand = s_tdata[68:37];
        instr_unpacked.immediate      = s_tdata[84:69];
        instr_unpacked.instr_address  = s_tdata[100:85];
    end

    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            instr_reg <= instr_unpacked;
        end
    end

    assign valid = valid_reg;
    assign instr = instr_reg;

endmodule

FILE: rtl/core/abe_exec_unit.sv
`timescale 1ns / 1ps

module abe_exec_unit
(
    input  abe_pkg::instr_t  instr,
    input  abe_pkg::flags_t  flags,
    output abe_pkg::result_t result,
    output abe_pkg::flags_t  flags_next
);
    import abe_pkg::*;

    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] s2;
    logic [WORD_W-1:0] lit;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] alu_res;
    logic              alu_en;
    logic              taken;
    cmd_t              cmd;

    function automatic flags_t sign_flags(input logic [WORD_W-1:0] r);
        flags_t f;
        f = '0;
        if (r == '0)
        begin
            f[FLAG_Z] = 1'b1;
        end
        else if (r[WORD_W-1])
        begin
            f[FLAG_N] = 1'b1;
        end
        else
        begin
            f[FLAG_P] = 1'b1;
        end
        return f;
    endfunction

    always_comb
    begin
        s1   = instr.first_operand;
        s2   = instr.second_operand;
        lit  = {{(WORD_W-IMM_W){instr.immediate[IMM_W-1]}}, instr.immediate};
        addr = {{(WORD_W-ADDR_W){1'b0}}, instr.instr_address};
        cmd  = cmd_t'(instr.command);

        result     = '0;
        flags_next = flags;
        alu_res    = '0;
        alu_en     = 1'b0;
        taken      = 1'b0;

        unique case (cmd)
            CMD_HALT:   result.halted = 1'b1;
            CMD_MOVC:
            begin
                result.dest_write = 1'b1;
                result.dest_value = lit;
            end
            CMD_ADD:    begin alu_res = s1 + s2; alu_en = 1'b1; end
            CMD_SUB:    begin alu_res = s1 - s2; alu_en = 1'b1; end
            CMD_MUL:    begin alu_res = s1 * s2; alu_en = 1'b1; end
            CMD_AND:    begin alu_res = s1 & s2; alu_en = 1'b1; end
            CMD_OR:     begin alu_res = s1 | s2; alu_en = 1'b1; end
            CMD_XOR:    begin alu_res = s1 ^ s2; alu_en = 1'b1; end
            CMD_ADDL:   begin alu_res = s1 + lit; alu_en = 1'b1; end
            CMD_SUBL:   begin alu_res = s1 - lit; alu_en = 1'b1; end
            CMD_CML:    flags_next = sign_flags(s1 - lit);
            CMD_CMP:    flags_next = sign_flags(s1 - s2);
            CMD_JUMP:
            begin
                result.redirect      = 1'b1;
                result.redirect_addr = s1 + lit;
            end
            CMD_BZ:     taken = flags[FLAG_Z];
            CMD_BNZ:    taken = !flags[FLAG_Z];
            CMD_BP:     taken = flags[FLAG_P];
            CMD_BNP:    taken = !flags[FLAG_P];
            CMD_BN:     taken = flags[FLAG_N];
            CMD_BNN:    taken = !flags[FLAG_N];
            CMD_LOAD, CMD_LOADP:
            begin
                result.mem_read = 1'b1;
                result.mem_addr = s1 + lit;
                if (cmd == CMD_LOADP)
                begin
                    result.base_write = 1'b1;
                    result.base_value = s1 + WORD_STEP;
                end
            end
            CMD_STORE, CMD_STOREP:
            begin
                result.mem_write  = 1'b1;
                result.mem_addr   = s2 + lit;
                result.store_data = s1;
                if (cmd == CMD_STOREP)
                begin
                    result.base_write = 1'b1;
                    result.base_value = s2 + WORD_STEP;
                end
            end
            CMD_JALR:
            begin
                result.dest_write    = 1'b1;
                result.dest_value    = addr + WORD_STEP;
                result.redirect      = 1'b1;
                result.redirect_addr = s1 + lit;
            end
            default:    ;
        endcase

        if (alu_en)
        begin
            result.dest_write = 1'b1;
            result.dest_value = alu_res;
            flags_next        = sign_flags(alu_res);
        end

        // Branch target is relative to the instruction address
        if (taken)
        begin
            result.redirect      = 1'b1;
            result.redirect_addr = addr + lit;
        end
    end

endmodule

FILE: rtl/core/alu_branch_execute_stage.sv
// Execute stage: ALU, compare, load/store address and branch resolution.
// Path: input register, then combinational execute, then the result register.
// One instruction per cycle unless m_tready stalls; ready passes back through both registers.
// Condition flags advance as each instruction moves into the result register.
// Reset (rst_n low, asynchronous): both stages empty, condition flags cleared.
`timescale 1ns / 1ps

module alu_branch_execute_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    // s_tdata: command[4:0], first_operand[36:5], second_operand[68:37],
    //          immediate[84:69], instr_address[100:85], zero fill [103:101]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [abe_pkg::IN_DATA_W-1:0]  s_tdata,
    // m_tdata: dest_write[0], dest_value[32:1], base_write[33], base_value[65:34],
    //          mem_read[66], mem_write[67], mem_addr[99:68], store_data[131:100],
    //          redirect[132], redirect_addr[164:133], halted[165], zero fill [167:166]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [abe_pkg::OUT_DATA_W-1:0] m_tdata
);
    import abe_pkg::*;

    logic    in_valid;
    instr_t  in_instr;
    logic    take;
    result_t exec_result;
    flags_t  exec_flags;

    logic    flags_any;
    flags_t  cond_flags_reg;
    flags_t  cond_flags_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;

    // Move the held instruction on whenever the result register is free or draining
    assign take = in_valid && (!out_valid_reg || m_tready);

    abe_input_stage u_input_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .valid    (in_valid),
        .instr    (in_instr)
    );

    abe_exec_unit u_exec_unit
    (
        .instr      (in_instr),
        .flags      (cond_flags_reg),
        .result     (exec_result),
        .flags_next (exec_flags)
    );

    // Flags only advance with the instruction that produced them, keeping program order
    always_comb
    begin
        cond_flags_next = take ? exec_flags : cond_flags_reg;
        flags_any       = cond_flags_reg != '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_flags_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cond_flags_reg <= cond_flags_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the result until the downstream transfer completes
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_result_reg <= exec_result;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata          = '0;
        m_tdata[0]       = out_result_reg.dest_write;
        m_tdata[32:1]    = out_result_reg.dest_value;
        m_tdata[33]      = out_result_reg.base_write;
        m_tdata[65:34]   = out_result_reg.base_value;
        m_tdata[66]      = out_result_reg.mem_read;
        m_tdata[67]      = out_result_reg.mem_write;
        m_tdata[99:68]   = out_result_reg.mem_addr;
        m_tdata[131:100] = out_result_reg.store_data;
        m_tdata[132]     = out_result_reg.redirect;
        m_tdata[164:133] = out_result_reg.redirect_addr;
        m_tdata[165]     = out_result_reg.halted;
    end

`ifndef SYNTHESIS
    // Flags are never more than one-hot
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cond_flags_reg))
        else $error("condition flags not one-hot");

    // Once a flag is set, one always stays set
    assert property (@(posedge clk) disable iff (!rst_n) flags_any |=> flags_any)
        else $error("condition flags returned to all clear");

    // A base update only comes with a memory request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.base_write) |->
        (out_result_reg.mem_read || out_result_reg.mem_write))
        else $error("base update without memory request");

    // A redirecting instruction never issues a memory request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.redirect) |->
        (!out_result_reg.mem_read && !out_result_reg.mem_write))
        else $error("redirect with memory request");
`endif

endmodule

FILE: bench/alu_branch_execute_stage_test.sv
`timescale 1ns / 1ps

module alu_branch_execute_stage_test;

    import abe_pkg::*;

    // Command codes the block leaves undefined; both behave as NOP
    localparam logic [CMD_W-1:0] CMD_SPARE_LOW  = 5'd25;
    localparam logic [CMD_W-1:0] CMD_SPARE_HIGH = 5'd31;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1625;
    localparam int HOLD_OFF_AFTER = 400;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 8;

    // One row of the directed table: an instruction and, where it is plain to
    // see, the result typed in by hand. Rows without one use the flag model.
    typedef struct {
        instr_t  instr;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Flag state of the model and the results still owed by the block
    flags_t    pnz_flags = '0;
    result_t   owed_results[$];
    stim_row_t directed_rows[$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  burst_left = 0;
    bit  hold_off = 1'b0;
    int  ready_mode = 0;
    int  mode_left = 0;
    bit  ready_phase = 1'b0;

    alu_branch_execute_stage dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Flag model: work out the result of one instruction and advance the
    // positive / negative / zero flags exactly as the stage should.
    // ------------------------------------------------------------------
    function automatic result_t predict_execute(instr_t it);
        result_t         r;
        logic [WORD_W-1:0] s1;
        logic [WORD_W-1:0] s2;
        logic [WORD_W-1:0] lit;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] acc;
        bit              sets_flags;
        bit              writes_dest;
        bit              taken;
        r           = '0;
        s1          = it.first_operand;
        s2          = it.second_operand;
        lit         = {{(WORD_W-IMM_W){it.immediate[IMM_W-1]}}, it.immediate};
        pc          = {{(WORD_W-ADDR_W){1'b0}}, it.instr_address};
        acc         = '0;
        sets_flags  = 1'b0;
        writes_dest = 1'b0;
        taken       = 1'b0;
        case (it.command)
            CMD_HALT:   r.halted = 1'b1;
            CMD_MOVC:
            begin
                r.dest_write = 1'b1;
                r.dest_value = lit;
            end
            CMD_ADD:    begin acc = s1 + s2;  sets_flags = 1'b1; writes_dest = 1'b1; end
            CMD_SUB:    begin acc = s1 - s2;  sets_flags = 1'b1; writes_dest = 1'b1; end
            CMD_MUL:    begin acc = s1 * s2;  sets_flags = 1'b1; writes_dest = 1'b1; end
            CMD_AND:    begin acc = s1 & s2;  sets_flags = 1'b1; writes_dest = 1'b1; end
            CMD_OR:     begin acc = s1 | s2;  sets_flags = 1'b1; writes_dest = 1'b1; end
            CMD_XOR:    begin acc = s1 ^ s2;  sets_flags = 1'b1; writes_dest = 1'b1; end
            CMD_ADDL:   begin acc = s1 + lit; sets_flags = 1'b1; writes_dest = 1'b1; end
            CMD_SUBL:   begin acc = s1 - lit; sets_flags = 1'b1; writes_dest = 1'b1; end
            // Compares touch the flags only
            CMD_CML:    begin acc = s1 - lit; sets_flags = 1'b1; end
            CMD_CMP:    begin acc = s1 - s2;  sets_flags = 1'b1; end
            CMD_JUMP:
            begin
                r.redirect      = 1'b1;
                r.redirect_addr = s1 + lit;
            end
            CMD_BZ:     taken = pnz_flags[FLAG_Z];
            CMD_BNZ:    taken = !pnz_flags[FLAG_Z];
            CMD_BP:     taken = pnz_flags[FLAG_P];
            CMD_BNP:    taken = !pnz_flags[FLAG_P];
            CMD_BN:     taken = pnz_flags[FLAG_N];
            CMD_BNN:    taken = !pnz_flags[FLAG_N];
            CMD_LOAD, CMD_LOADP:
            begin
                r.mem_read = 1'b1;
                r.mem_addr = s1 + lit;
                if (it.command == CMD_LOADP)
                begin
                    r.base_write = 1'b1;
                    r.base_value = s1 + WORD_STEP;
                end
            end
            CMD_STORE, CMD_STOREP:
            begin
                r.mem_write  = 1'b1;
                r.mem_addr   = s2 + lit;
                r.store_data = s1;
                if (it.command == CMD_STOREP)
                begin
                    r.base_write = 1'b1;
                    r.base_value = s2 + WORD_STEP;
                end
            end
            CMD_JALR:
            begin
                r.dest_write    = 1'b1;
                r.dest_value    = pc + WORD_STEP;
                r.redirect      = 1'b1;
                r.redirect_addr = s1 + lit;
            end
            default: ;
        endcase
        if (writes_dest)
        begin
            r.dest_write = 1'b1;
            r.dest_value = acc;
        end
        if (sets_flags)
        begin
            // Exactly one flag survives each update
            pnz_flags = '0;
            if (acc == '0)
                pnz_flags[FLAG_Z] = 1'b1;
            else if (acc[WORD_W-1])
                pnz_flags[FLAG_N] = 1'b1;
            else
                pnz_flags[FLAG_P] = 1'b1;
        end
        if (taken)
        begin
            r.redirect      = 1'b1;
            r.redirect_addr = pc + lit;
        end
        return r;
    endfunction

    function automatic stim_row_t row(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] s1,
                                      logic [WORD_W-1:0] s2, logic [IMM_W-1:0] imm,
                                      logic [ADDR_W-1:0] pc, bit typed,
                                      logic dest_wr, logic [WORD_W-1:0] dest_val,
                                      logic redir, logic [WORD_W-1:0] redir_addr,
                                      logic halt);
        stim_row_t s;
        s.instr.command         = cmd;
        s.instr.first_operand   = s1;
        s.instr.second_operand  = s2;
        s.instr.immediate       = imm;
        s.instr.instr_address   = pc;
        s.typed                 = typed;
        s.want                  = '0;
        s.want.dest_write       = dest_wr;
        s.want.dest_value       = dest_val;
        s.want.redirect         = redir;
        s.want.redirect_addr    = redir_addr;
        s.want.halted           = halt;
        return s;
    endfunction

    // Operand values lean on the edges of the 32-bit range
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            it.command = CMD_W'(CMD_BZ + $urandom_range(0, 5));
        else if (pick < 60)
            case ($urandom_range(0, 9))
                0:       it.command = CMD_ADD;
                1:       it.command = CMD_SUB;
                2:       it.command = CMD_MUL;
                3:       it.command = CMD_AND;
                4:       it.command = CMD_OR;
                5:       it.command = CMD_XOR;
                6:       it.command = CMD_ADDL;
                7:       it.command = CMD_SUBL;
                8:       it.command = CMD_CML;
                default: it.command = CMD_CMP;
            endcase
        else if (pick < 95)
            it.command = CMD_W'($urandom_range(CMD_NOP, CMD_JALR));
        else
            it.command = CMD_W'($urandom_range(CMD_SPARE_LOW, CMD_SPARE_HIGH));
        it.first_operand  = pick_word();
        it.second_operand = pick_word();
        case ($urandom_range(0, 7))
            0:       it.immediate = 16'h0000;
            1:       it.immediate = 16'h7FFF;
            2:       it.immediate = 16'h8000;
            3:       it.immediate = 16'hFFFF;
            default: it.immediate = IMM_W'($urandom);
        endcase
        it.instr_address = ADDR_W'($urandom);
        // Force equal operands now and then so compares and subtracts hit zero
        if ($urandom_range(0, 5) == 0)
            it.second_operand = it.first_operand;
        if ($urandom_range(0, 7) == 0)
            it.first_operand = {{(WORD_W-IMM_W){it.immediate[IMM_W-1]}}, it.immediate};
        return it;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_instr(instr_t it);
        return {{(IN_DATA_W-101){1'b0}}, it.instr_address, it.immediate,
                it.second_operand, it.first_operand, it.command};
    endfunction

    function automatic result_t unpack_result(logic [OUT_DATA_W-1:0] d);
        result_t r;
        r.dest_write    = d[0];
        r.dest_value    = d[32:1];
        r.base_write    = d[33];
        r.base_value    = d[65:34];
        r.mem_read      = d[66];
        r.mem_write     = d[67];
        r.mem_addr      = d[99:68];
        r.store_data    = d[131:100];
        r.redirect      = d[132];
        r.redirect_addr = d[164:133];
        r.halted        = d[165];
        return r;
    endfunction

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Offer one instruction and hold it until the transfer completes.
    // Called and returns at a rising edge. Between bursts, drop tvalid for
    // a random gap; within a burst keep it high so the next item is offered
    // straight away.
    // ------------------------------------------------------------------
    task automatic send_instr(instr_t it, bit typed, result_t want);
        result_t modelled;
        int      gap;
        s_tdata  <= pack_instr(it);
        s_tvalid <= 1'b1;
        // tready is steady from the falling edge to the next rising edge
        do
            @(negedge clk);
        while (s_tready !== 1'b1);
        @(posedge clk);
        modelled = predict_execute(it);
        owed_results.push_back(typed ? want : modelled);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            // Roughly a third of the bursts run straight into the next one
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Result side: a transfer seen at the falling edge completes at the next
    // rising edge, so compare it against the oldest owed result here.
    always @(negedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got = unpack_result(m_tdata);
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("dest_write",    WORD_W'(want.dest_write), WORD_W'(got.dest_write));
                check_field("dest_value",    want.dest_value,    got.dest_value);
                check_field("base_write",    WORD_W'(want.base_write), WORD_W'(got.base_write));
                check_field("base_value",    want.base_value,    got.base_value);
                check_field("mem_read",      WORD_W'(want.mem_read),   WORD_W'(got.mem_read));
                check_field("mem_write",     WORD_W'(want.mem_write),  WORD_W'(got.mem_write));
                check_field("mem_addr",      want.mem_addr,      got.mem_addr);
                check_field("store_data",    want.store_data,    got.store_data);
                check_field("redirect",      WORD_W'(want.redirect),   WORD_W'(got.redirect));
                check_field("redirect_addr", want.redirect_addr, got.redirect_addr);
                check_field("halted",        WORD_W'(want.halted),     WORD_W'(got.halted));
            end
        end
    end

    // Receiver stalls on its own pattern: always ready, mostly ready, mostly
    // stalled or alternating, each held for a random stretch of cycles.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        ready_phase = ~ready_phase;
        if (hold_off)
            m_tready <= 1'b0;
        else
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ready_phase;
            endcase
    end

    // Back-pressure: once traffic is flowing, hold the receiver off long
    // enough for both stage registers to fill and tready to drop.
    initial
    begin
        while (items_sent < HOLD_OFF_AFTER)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("alu_branch_execute_stage_test: done, errors");
        $finish;
    end

    initial
    begin
        int      waited;
        result_t no_result;
        no_result = '0;

        // Directed table. The first six rows run on the cleared flags: the
        // three negated branches are taken, the other three fall through.
        directed_rows.push_back(row(CMD_BNZ, 0, 0, 16'h0010, 16'h0100, TYPED,
                                    0, 0, 1, 32'h0000_0110, 0));
        directed_rows.push_back(row(CMD_BNP, 0, 0, 16'hFFFC, 16'h0200, TYPED,
                                    0, 0, 1, 32'h0000_01FC, 0));
        directed_rows.push_back(row(CMD_BNN, 0, 0, 16'h7FFF, 16'hFFFF, TYPED,
                                    0, 0, 1, 32'h0001_7FFE, 0));
        directed_rows.push_back(row(CMD_BZ, 0, 0, 16'h8000, 16'hFFFF, TYPED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_BP, 0, 0, 16'h0004, 16'h0040, TYPED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_BN, 0, 0, 16'h0004, 16'h0040, TYPED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                                    TYPED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_HALT, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h0000,
                                    TYPED, 0, 0, 0, 0, 1));
        directed_rows.push_back(row(CMD_MOVC, 0, 0, 16'h8000, 16'h1234, TYPED,
                                    1, 32'hFFFF_8000, 0, 0, 0));
        directed_rows.push_back(row(CMD_SPARE_HIGH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                    16'hFFFF, TYPED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_JALR, 0, 0, 16'h0000, 16'hFFFF, TYPED,
                                    1, 32'h0001_0003, 1, 32'h0000_0000, 0));
        // Signed overflow into the negative flag, then the rest of the set
        directed_rows.push_back(row(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 0, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_SUB, 32'h8000_0000, 32'h8000_0000, 0, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_AND, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 0, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_OR, 32'h8000_0000, 32'h0000_0001, 0, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_XOR, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_CML, 32'hFFFF_8000, 0, 16'h8000, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_JUMP, 32'hFFFF_FFFF, 0, 16'h7FFF, 16'h8000,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_ADDL, 32'h7FFF_FFFF, 0, 16'h7FFF, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_SUBL, 32'h8000_0000, 0, 16'h0001, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_LOAD, 32'h0000_1000, 0, 16'h8000, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_LOADP, 32'hFFFF_FFFC, 0, 16'hFFFF, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_STORE, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 16'h0001, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(CMD_STOREP, 32'h1234_5678, 32'h7FFF_FFFE, 16'h7FFF, 0,
                                    PREDICTED, 0, 0, 0, 0, 0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_instr(directed_rows[i].instr, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_instr(random_instr(), PREDICTED, no_result);

        // Hold tvalid low only if the last transfer left it high
        if (s_tvalid)
            s_tvalid <= 1'b0;

        // Drain: wait for every owed result, then let the pipeline settle
        waited = 0;
        while (owed_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (owed_results.size() != 0)
        begin
            $display("%0t: %0d results expected, none arrived", $time, owed_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("alu_branch_execute_stage_test: done, clean");
        else
            $display("alu_branch_execute_stage_test: done, errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/abe_pkg.sv
rtl/core/abe_input_stage.sv
rtl/core/abe_exec_unit.sv
rtl/core/alu_branch_execute_stage.sv
bench/alu_branch_execute_stage_test.sv
